>>> rtl/vdc_pkg.sv
// Shared types and constants for the ventilation duty-cycle controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package vdc_pkg;

	// Field widths fixed by the interface.
	localparam int TEMP_W    = 16;
	localparam int WORD_W    = 64;
	localparam int MASK_W    = 24;
	localparam int GRADE_W   = 3;
	localparam int LEN_W     = 12;
	localparam int CNT_W     = 13;
	localparam int CFG_IDX_W = 3;

	// Six sensor ports and at most five grade registers exist.
	localparam int NUM_TEMP_PORTS = 6;
	localparam int MAX_GRADE_REGS = 5;

	// Signed width of the sensor sum and of the scaled thresholds (up to eight sensors).
	localparam int CMP_W = 21;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SET_TEMP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRADE0   = 3'd1;

	// Bit positions inside a grade word.
	localparam int OFS_LSB   = 0;
	localparam int CYCLE_LSB = 16;
	localparam int RUN_LSB   = 28;
	localparam int FAN_LSB   = 40;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [WORD_W-1:0]        grade_word_t;

	// Flags of one input beat that steer the duty-cycle logic.
	typedef struct packed {
		logic started;
		logic cooling;
	} step_flags_t;

	// One result beat.
	typedef struct packed {
		logic [MASK_W-1:0]  fan_mask;
		logic               fan_command;
		logic [GRADE_W-1:0] grade_level;
		logic               grade_updated;
	} result_t;

	function automatic temp_t grade_offset(input grade_word_t w);
		return temp_t'(w[OFS_LSB +: TEMP_W]);
	endfunction

	function automatic logic [LEN_W-1:0] grade_cycle(input grade_word_t w);
		return w[CYCLE_LSB +: LEN_W];
	endfunction

	function automatic logic [LEN_W-1:0] grade_run(input grade_word_t w);
		return w[RUN_LSB +: LEN_W];
	endfunction

	function automatic logic [MASK_W-1:0] grade_fans(input grade_word_t w);
		return w[FAN_LSB +: MASK_W];
	endfunction

endpackage

>>> rtl/vdc_grade_pick.sv
// Grade selection: compares the sensor sum against each grade threshold.
// Depends on vdc_pkg.
`timescale 1ns / 1ps

module vdc_grade_pick #(
	parameter int NUM_GRADES  = 5,
	parameter int NUM_SENSORS = 6
) (
	input  vdc_pkg::temp_t                      temps [vdc_pkg::NUM_TEMP_PORTS],
	input  vdc_pkg::temp_t                      set_temp,
	input  vdc_pkg::grade_word_t                words [NUM_GRADES],
	output logic [vdc_pkg::GRADE_W-1:0]         grade
);
	import vdc_pkg::*;

	logic signed [CMP_W-1:0] sum;
	logic [NUM_GRADES-1:0]   hit;

	// Sum of the active sensors; sensors beyond the six ports read as zero.
	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_TEMP_PORTS; i++) begin
			if (i < NUM_SENSORS) begin
				sum = sum + CMP_W'(temps[i]);
			end
		end
	end

	// The average lies below a threshold exactly when sum < NUM_SENSORS * threshold.
	always_comb begin
		logic signed [TEMP_W:0]  thr;
		logic signed [CMP_W-1:0] scaled;
		for (int g = 0; g < NUM_GRADES; g++) begin
			thr    = (TEMP_W+1)'(set_temp) + (TEMP_W+1)'(grade_offset(words[g]));
			scaled = $signed(CMP_W'(NUM_SENSORS)) * CMP_W'(thr);
			hit[g] = sum < scaled;
		end
	end

	// First grade that hits, else the last grade.
	always_comb begin
		grade = GRADE_W'(NUM_GRADES - 1);
		for (int g = NUM_GRADES - 1; g >= 0; g--) begin
			if (hit[g]) begin
				grade = GRADE_W'(g);
			end
		end
	end

endmodule

>>> rtl/vdc_duty_fsm.sv
// Duty-cycle state: grading, idle count, run count and fan state, one beat per step.
// Depends on vdc_pkg.
`timescale 1ns / 1ps

module vdc_duty_fsm #(
	parameter int NUM_GRADES = 5,
	parameter int FAN_BITS   = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  vdc_pkg::step_flags_t        flags,
	input  logic [vdc_pkg::GRADE_W-1:0] picked,
	input  vdc_pkg::grade_word_t        words [NUM_GRADES],
	output vdc_pkg::result_t            result
);
	import vdc_pkg::*;

	localparam int GIDX_W = $clog2(NUM_GRADES);
	localparam logic [MASK_W-1:0] FAN_KEEP = MASK_W'((25'd1 << FAN_BITS) - 25'd1);

	logic               pending_q, pending_n;
	logic               phase_q, phase_n;
	logic [GRADE_W-1:0] grade_q, grade_n;
	logic [CNT_W-1:0]   idle_q, idle_n;
	logic [CNT_W-1:0]   run_cnt_q, run_cnt_n;
	logic [LEN_W-1:0]   run_len_q, run_len_n;
	logic [MASK_W-1:0]  fans_q, fans_n;
	logic               cmd, upd;

	grade_word_t        word;
	logic [GRADE_W-1:0] grade_eff;
	logic [LEN_W-1:0]   cycle, run;
	logic [CNT_W-1:0]   idle_inc, run_inc;
	logic signed [CNT_W:0] idle_target;

	// A pending grading takes effect on this very beat.
	assign grade_eff   = pending_q ? picked : grade_q;
	assign word        = words[grade_eff[GIDX_W-1:0]];
	assign cycle       = grade_cycle(word);
	assign run         = grade_run(word);
	assign idle_inc    = (pending_q ? '0 : idle_q) + CNT_W'(1);
	assign run_inc     = run_cnt_q + CNT_W'(1);
	assign idle_target = $signed({2'b00, cycle}) - $signed({2'b00, run});

	// Next-state logic for one tick.
	always_comb begin
		pending_n = pending_q;
		phase_n   = phase_q;
		grade_n   = grade_q;
		idle_n    = idle_q;
		run_cnt_n = run_cnt_q;
		run_len_n = run_len_q;
		fans_n    = fans_q;
		cmd       = 1'b0;
		upd       = 1'b0;
		if (!flags.started) begin
			fans_n = '0;
			cmd    = 1'b1;
		end else if (flags.cooling) begin
			pending_n = 1'b1;
		end else begin
			if (pending_q) begin
				grade_n   = picked;
				pending_n = 1'b0;
				phase_n   = 1'b0;
				upd       = 1'b1;
			end
			if (pending_q || !phase_q) begin
				// Idle phase: count up until the idle target is reached.
				idle_n = idle_inc;
				if ($signed({1'b0, idle_inc}) >= idle_target) begin
					run_len_n = run;
					run_cnt_n = '0;
					phase_n   = 1'b1;
					if (run != '0) begin
						fans_n = grade_fans(word) & FAN_KEEP;
						cmd    = 1'b1;
					end
				end
			end else begin
				// Run phase: fans off at the end unless they run the whole cycle.
				run_cnt_n = run_inc;
				if (run_inc >= CNT_W'(run_len_q)) begin
					if (run_len_q != cycle) begin
						fans_n = '0;
						cmd    = 1'b1;
					end
					pending_n = 1'b1;
				end
			end
		end
	end

	// State registers advance once per processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b1;
			phase_q   <= 1'b0;
			grade_q   <= '0;
			idle_q    <= '0;
			run_cnt_q <= '0;
			run_len_q <= '0;
			fans_q    <= '0;
		end else if (step) begin
			pending_q <= pending_n;
			phase_q   <= phase_n;
			grade_q   <= grade_n;
			idle_q    <= idle_n;
			run_cnt_q <= run_cnt_n;
			run_len_q <= run_len_n;
			fans_q    <= fans_n;
		end
	end

	assign result.fan_mask      = fans_n;
	assign result.fan_command   = cmd;
	assign result.grade_level   = grade_n;
	assign result.grade_updated = upd;

endmodule

>>> rtl/ventilation_duty_cycle_controller_core.sv
// Top level of the ventilation duty-cycle controller: config registers, input and result stages.
// Depends on vdc_pkg, vdc_grade_pick and vdc_duty_fsm.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    process_running, cooling_active, temp_a .. temp_f
// output    out_valid / out_ready  fan_mask, fan_command, grade_level, grade_updated
// config    cfg_wr_en              cfg_index, cfg_data (write only, no wait)
//
// A beat is captured in the input register, processed combinationally and its result
// is held in the result register; one beat per cycle is sustained while out_ready is high.
// The pace is set by the state update between the two registers.
// Reset clears the timing state and all configuration registers; no clearing pass.
// A stalled result register holds the input register, and in_ready drops while that register holds a beat.

module ventilation_duty_cycle_controller_core #(
	parameter int NUM_GRADES  = 5,
	parameter int NUM_SENSORS = 6,
	parameter int FAN_BITS    = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [vdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vdc_pkg::WORD_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          process_running,
	input  logic                          cooling_active,
	input  vdc_pkg::temp_t                temp_a,
	input  vdc_pkg::temp_t                temp_b,
	input  vdc_pkg::temp_t                temp_c,
	input  vdc_pkg::temp_t                temp_d,
	input  vdc_pkg::temp_t                temp_e,
	input  vdc_pkg::temp_t                temp_f,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vdc_pkg::MASK_W-1:0]    fan_mask,
	output logic                          fan_command,
	output logic [vdc_pkg::GRADE_W-1:0]   grade_level,
	output logic                          grade_updated
);
	import vdc_pkg::*;

	temp_t       set_temp_q;
	grade_word_t words [NUM_GRADES];

	logic        valid_s1;
	step_flags_t flags_s1;
	temp_t       temps_s1 [NUM_TEMP_PORTS];
	logic        advance;
	logic        in_take;

	logic [GRADE_W-1:0] picked;
	result_t            result;
	result_t            res_q;
	logic               res_valid_q;

	// Set temperature register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_temp_q <= '0;
		end else if (cfg_wr_en && cfg_index == REG_SET_TEMP) begin
			set_temp_q <= temp_t'(cfg_data[TEMP_W-1:0]);
		end
	end

	// Grade registers; grades without a register read as zero.
	for (genvar g = 0; g < NUM_GRADES; g++) begin : g_grade
		if (g < MAX_GRADE_REGS) begin : g_reg
			grade_word_t word_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					word_q <= '0;
				end else if (cfg_wr_en && cfg_index == REG_GRADE0 + CFG_IDX_W'(g)) begin
					word_q <= cfg_data;
				end
			end
			assign words[g] = word_q;
		end else begin : g_zero
			assign words[g] = '0;
		end
	end

	// Input stage: moves on when the result register is free or being drained.
	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			flags_s1.started <= process_running;
			flags_s1.cooling <= cooling_active;
			temps_s1[0]      <= temp_a;
			temps_s1[1]      <= temp_b;
			temps_s1[2]      <= temp_c;
			temps_s1[3]      <= temp_d;
			temps_s1[4]      <= temp_e;
			temps_s1[5]      <= temp_f;
		end
	end

	vdc_grade_pick #(
		.NUM_GRADES  (NUM_GRADES),
		.NUM_SENSORS (NUM_SENSORS)
	) u_pick (
		.temps    (temps_s1),
		.set_temp (set_temp_q),
		.words    (words),
		.grade    (picked)
	);

	vdc_duty_fsm #(
		.NUM_GRADES (NUM_GRADES),
		.FAN_BITS   (FAN_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.flags  (flags_s1),
		.picked (picked),
		.words  (words),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign out_valid     = res_valid_q;
	assign fan_mask      = res_q.fan_mask;
	assign fan_command   = res_q.fan_command;
	assign grade_level   = res_q.grade_level;
	assign grade_updated = res_q.grade_updated;

`ifndef SYNTHESIS
	// A stopped tick always yields fans off with a command.
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !flags_s1.started |=> res_q.fan_mask == '0 && res_q.fan_command)
		else $error("stopped tick did not clear the fans");

	// Input backpressure only comes from a stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// The grade in use always names an existing grade.
	a_grade_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, grade_level} < (GRADE_W+1)'(NUM_GRADES))
		else $error("grade level out of range");

	// A fresh grade is reported only on a running tick.
	a_update_running: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.grade_updated |-> flags_s1.started && !flags_s1.cooling)
		else $error("grade update on a stopped or cooling tick");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the ventilation duty-cycle controller core.
// Depends on vdc_pkg and ventilation_duty_cycle_controller_core; runs directed ticks, then random phases.
`timescale 1ns / 1ps

module tb;
	import vdc_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int RAND_PHASES     = 8;
	localparam int TICKS_PER_PHASE = 56;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_AT         = 200;
	localparam int HOLD_CYCLES     = 80;

	localparam temp_t TEMP_MIN = 16'sh8000;
	localparam temp_t TEMP_MAX = 16'sh7FFF;

	// Registers past the last grade word; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_GRADE0 + MAX_GRADE_REGS);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(REG_GRADE0 + MAX_GRADE_REGS + 1);

	// One tick as driven on the input channel.
	typedef struct packed {
		logic                                       started;
		logic                                       cooling;
		logic [NUM_TEMP_PORTS-1:0][TEMP_W-1:0]      temps;
	} tick_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

	// One row of the directed plan: a register write or a tick.
	typedef struct {
		row_kind_e              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [WORD_W-1:0]      val;
		tick_t                  tk;
		logic                   typed;
		result_t                want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   process_running = 1'b0;
	logic                   cooling_active = 1'b0;
	temp_t                  temp_a = '0;
	temp_t                  temp_b = '0;
	temp_t                  temp_c = '0;
	temp_t                  temp_d = '0;
	temp_t                  temp_e = '0;
	temp_t                  temp_f = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [MASK_W-1:0]      fan_mask;
	logic                   fan_command;
	logic [GRADE_W-1:0]     grade_level;
	logic                   grade_updated;

	ventilation_duty_cycle_controller_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.process_running(process_running),
		.cooling_active (cooling_active),
		.temp_a         (temp_a),
		.temp_b         (temp_b),
		.temp_c         (temp_c),
		.temp_d         (temp_d),
		.temp_e         (temp_e),
		.temp_f         (temp_f),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.fan_mask       (fan_mask),
		.fan_command    (fan_command),
		.grade_level    (grade_level),
		.grade_updated  (grade_updated)
	);

	always #6 clk = ~clk;

	// Shadow copy of the configuration registers.
	temp_t             set_temp_cfg = '0;
	logic [WORD_W-1:0] grade_cfg [MAX_GRADE_REGS];

	// Shadow copy of the duty-cycle state.
	logic               need_grade   = 1'b1;
	logic               fans_running = 1'b0;
	logic [GRADE_W-1:0] grade_now    = '0;
	logic [CNT_W-1:0]   idle_ticks   = '0;
	logic [CNT_W-1:0]   run_ticks    = '0;
	logic [LEN_W-1:0]   run_len      = '0;
	logic [MASK_W-1:0]  fans_on      = '0;

	result_t fan_results_due [$];
	row_t    plan [$];

	logic idle_on = 1'b1;
	int   mismatches = 0;
	int   results_seen = 0;
	int   ticks_sent = 0;
	int   cfg_writes = 0;
	int   cycle_count = 0;

	initial begin
		for (int g = 0; g < MAX_GRADE_REGS; g++) begin
			grade_cfg[g] = '0;
		end
	end

	function automatic logic [WORD_W-1:0] pack_grade(input int ofs, input int cyc, input int rn,
			input logic [MASK_W-1:0] fans);
		logic [15:0] o;
		logic [11:0] c;
		logic [11:0] r;
		o = 16'(ofs);
		c = 12'(cyc);
		r = 12'(rn);
		return {fans, r, c, o};
	endfunction

	function automatic temp_t clamp_temp(input int v);
		if (v > 32767) return TEMP_MAX;
		if (v < -32768) return TEMP_MIN;
		return temp_t'(v);
	endfunction

	// Even sensors read lo, odd sensors read hi.
	function automatic tick_t mk_tick(input logic s, input logic c, input temp_t lo, input temp_t hi);
		tick_t tk;
		tk.started = s;
		tk.cooling = c;
		for (int i = 0; i < NUM_TEMP_PORTS; i++) begin
			tk.temps[i] = (i % 2 == 0) ? lo : hi;
		end
		return tk;
	endfunction

	function automatic result_t exp_res(input logic [MASK_W-1:0] m, input logic c,
			input logic [GRADE_W-1:0] g, input logic u);
		result_t r;
		r.fan_mask      = m;
		r.fan_command   = c;
		r.grade_level   = g;
		r.grade_updated = u;
		return r;
	endfunction

	function automatic row_t tick_row(input tick_t tk, input logic typed, input result_t want);
		row_t r;
		r.kind  = ROW_TICK;
		r.idx   = '0;
		r.val   = '0;
		r.tk    = tk;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		row_t r;
		r.kind  = ROW_WRITE;
		r.idx   = idx;
		r.val   = val;
		r.tk    = '0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	// Advances the duty-cycle state by one tick and returns the beat it must produce.
	function automatic result_t step_duty_cycle(input tick_t tk);
		result_t           r;
		int                sum;
		int                thr;
		int                cyc;
		int                rn;
		logic              found;
		logic [WORD_W-1:0] w;
		r = '0;
		if (!tk.started) begin
			fans_on = '0;
			r.fan_command = 1'b1;
		end else if (tk.cooling) begin
			need_grade = 1'b1;
		end else begin
			// Grade choice compares the sensor sum with the scaled threshold.
			if (need_grade) begin
				sum = 0;
				for (int i = 0; i < NUM_TEMP_PORTS; i++) begin
					sum += int'($signed(tk.temps[i]));
				end
				grade_now = GRADE_W'(MAX_GRADE_REGS - 1);
				found = 1'b0;
				for (int g = 0; g < MAX_GRADE_REGS; g++) begin
					thr = int'(set_temp_cfg) + int'($signed(grade_cfg[g][OFS_LSB +: TEMP_W]));
					if (!found && sum < NUM_TEMP_PORTS * thr) begin
						grade_now = GRADE_W'(g);
						found = 1'b1;
					end
				end
				need_grade = 1'b0;
				fans_running = 1'b0;
				idle_ticks = '0;
				r.grade_updated = 1'b1;
			end
			w = grade_cfg[grade_now];
			cyc = int'(w[CYCLE_LSB +: LEN_W]);
			rn = int'(w[RUN_LSB +: LEN_W]);
			if (!fans_running) begin
				// Idle phase: wait until the count reaches cycle minus run.
				idle_ticks = idle_ticks + 1'b1;
				if (int'(idle_ticks) >= cyc - rn) begin
					run_len = w[RUN_LSB +: LEN_W];
					run_ticks = '0;
					if (rn > 0) begin
						fans_on = w[FAN_LSB +: MASK_W];
						r.fan_command = 1'b1;
					end
					fans_running = 1'b1;
				end
			end else begin
				// Run phase: fans stay on when the run fills the whole cycle.
				run_ticks = run_ticks + 1'b1;
				if (int'(run_ticks) >= int'(run_len)) begin
					if (int'(run_len) != cyc) begin
						fans_on = '0;
						r.fan_command = 1'b1;
					end
					need_grade = 1'b1;
				end
			end
		end
		r.fan_mask = fans_on;
		r.grade_level = grade_now;
		return r;
	endfunction

	function automatic tick_t random_tick();
		tick_t tk;
		int    centre;
		tk.started = $urandom_range(0, 99) >= 6;
		tk.cooling = $urandom_range(0, 99) < 7;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < NUM_TEMP_PORTS; i++) begin
				tk.temps[i] = TEMP_W'($urandom);
			end
		end else begin
			// Cluster the sensors near the set point so that every grade gets picked.
			centre = int'(set_temp_cfg) + int'($urandom_range(0, 8000)) - 4000;
			for (int i = 0; i < NUM_TEMP_PORTS; i++) begin
				tk.temps[i] = clamp_temp(centre + int'($urandom_range(0, 600)) - 300);
			end
		end
		return tk;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("[%0t] %s: got 'h%0h, expected 'h%0h (result %0d)",
			$time, what, got, want, results_seen);
	endtask

	// Writes one register at the next rising edge; the caller lowers the enable.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		int g;
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		g = int'(idx) - int'(REG_GRADE0);
		if (idx == REG_SET_TEMP) begin
			set_temp_cfg = temp_t'(val[TEMP_W-1:0]);
		end else if (g >= 0 && g < MAX_GRADE_REGS) begin
			grade_cfg[g] = val;
		end
		cfg_writes++;
	endtask

	// Waits for every due result, then lets the pipeline run empty.
	task automatic settle();
		while (fan_results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offers one beat, with an optional gap first, and records its expected result.
	task automatic drive_tick(input tick_t tk, input logic typed, input result_t want);
		int      gap;
		result_t predicted;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		process_running <= tk.started;
		cooling_active  <= tk.cooling;
		temp_a          <= temp_t'(tk.temps[0]);
		temp_b          <= temp_t'(tk.temps[1]);
		temp_c          <= temp_t'(tk.temps[2]);
		temp_d          <= temp_t'(tk.temps[3]);
		temp_e          <= temp_t'(tk.temps[4]);
		temp_f          <= temp_t'(tk.temps[5]);
		do @(posedge clk); while (!in_ready);
		predicted = step_duty_cycle(tk);
		fan_results_due.push_back(typed ? want : predicted);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Result checker: every accepted beat against the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (fan_results_due.size() == 0) begin
				report_mismatch("result beat with nothing due", fan_mask, 0);
			end else begin
				want = fan_results_due.pop_front();
				if (fan_mask !== want.fan_mask)
					report_mismatch("fan_mask", fan_mask, want.fan_mask);
				if (fan_command !== want.fan_command)
					report_mismatch("fan_command", fan_command, want.fan_command);
				if (grade_level !== want.grade_level)
					report_mismatch("grade_level", grade_level, want.grade_level);
				if (grade_updated !== want.grade_updated)
					report_mismatch("grade_updated", grade_updated, want.grade_updated);
			end
			results_seen++;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still due",
				cycle_count, fan_results_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: short random stalls, plus one long hold-off that backs up the input.
	initial begin : receiver
		int   stall_left = 0;
		int   hold_left = 0;
		logic hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus.
	initial begin : stimulus
		row_t              r;
		logic [WORD_W-1:0] w;
		int                cyc;
		int                rn;

		// Reset configuration: all grade words zero, so every threshold is zero.
		plan.push_back(tick_row(mk_tick(1'b1, 1'b0, '0, '0), 1'b1,
			exp_res('0, 1'b0, 3'd4, 1'b1)));
		plan.push_back(tick_row(mk_tick(1'b1, 1'b0, '0, '0), 1'b1,
			exp_res('0, 1'b0, 3'd4, 1'b0)));
		plan.push_back(tick_row(mk_tick(1'b1, 1'b0, TEMP_MIN, TEMP_MIN), 1'b1,
			exp_res('0, 1'b0, 3'd0, 1'b1)));
		plan.push_back(tick_row(mk_tick(1'b1, 1'b0, TEMP_MAX, TEMP_MIN), 1'b1,
			exp_res('0, 1'b0, 3'd0, 1'b0)));
		plan.push_back(tick_row(mk_tick(1'b1, 1'b0, TEMP_MIN, TEMP_MAX), 1'b1,
			exp_res('0, 1'b0, 3'd0, 1'b1)));
		// Stopped, then cooling, then a forced regrade.
		plan.push_back(tick_row(mk_tick(1'b0, 1'b0, TEMP_MAX, TEMP_MAX), 1'b1,
			exp_res('0, 1'b1, 3'd0, 1'b0)));
		plan.push_back(tick_row(mk_tick(1'b1, 1'b1, TEMP_MAX, TEMP_MAX), 1'b1,
			exp_res('0, 1'b0, 3'd0, 1'b0)));
		plan.push_back(tick_row(mk_tick(1'b1, 1'b0, TEMP_MAX, TEMP_MAX), 1'b1,
			exp_res('0, 1'b0, 3'd4, 1'b1)));

		// Grades spaced 5 degrees apart around a 20 degree set point.
		plan.push_back(write_row(REG_SET_TEMP, 64'd2000));
		plan.push_back(write_row(REG_GRADE0, pack_grade(-500, 3, 2, 24'hA5A5A5)));
		plan.push_back(write_row(CFG_IDX_W'(REG_GRADE0 + 1), pack_grade(0, 2, 2, 24'h00FFFF)));
		plan.push_back(write_row(CFG_IDX_W'(REG_GRADE0 + 2), pack_grade(500, 1, 3, 24'hFFFFFF)));
		plan.push_back(write_row(CFG_IDX_W'(REG_GRADE0 + 3), pack_grade(1000, 4, 0, 24'h123456)));
		plan.push_back(write_row(CFG_IDX_W'(REG_GRADE0 + 4),
			pack_grade(-32768, 5, 3, 24'h800001)));
		plan.push_back(write_row(REG_SPARE_LO, '1));
		plan.push_back(write_row(REG_SPARE_HI, '1));

		// Normal duty cycle, interrupted by cooling.
		repeat (4) plan.push_back(tick_row(mk_tick(1'b1, 1'b0, temp_t'(1000), temp_t'(1000)),
			1'b0, '0));
		plan.push_back(tick_row(mk_tick(1'b1, 1'b1, temp_t'(1000), temp_t'(1000)), 1'b0, '0));
		// Run equal to cycle keeps the fans on across the regrade.
		repeat (4) plan.push_back(tick_row(mk_tick(1'b1, 1'b0, temp_t'(1900), temp_t'(1900)),
			1'b0, '0));
		// Run longer than cycle starts at once.
		repeat (2) plan.push_back(tick_row(mk_tick(1'b1, 1'b0, temp_t'(2400), temp_t'(2400)),
			1'b0, '0));
		plan.push_back(tick_row(mk_tick(1'b0, 1'b1, temp_t'(2400), temp_t'(2400)), 1'b0, '0));
		// Zero run time switches nothing on.
		repeat (3) plan.push_back(tick_row(mk_tick(1'b1, 1'b0, temp_t'(2900), temp_t'(2900)),
			1'b0, '0));
		repeat (2) plan.push_back(tick_row(mk_tick(1'b1, 1'b0, temp_t'(3500), temp_t'(3400)),
			1'b0, '0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			r = plan[i];
			if (r.kind == ROW_WRITE) begin
				in_valid <= 1'b0;
				settle();
				write_reg(r.idx, r.val);
				cfg_wr_en <= 1'b0;
			end else begin
				drive_tick(r.tk, r.typed, r.want);
			end
		end

		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			in_valid <= 1'b0;
			settle();
			if (ph == 0) begin
				write_reg(REG_SET_TEMP, 64'd32767);
				for (int g = 0; g < MAX_GRADE_REGS; g++)
					write_reg(CFG_IDX_W'(REG_GRADE0 + g), '1);
			end else if (ph == 1) begin
				write_reg(REG_SET_TEMP, {48'd0, TEMP_MIN});
				for (int g = 0; g < MAX_GRADE_REGS; g++)
					write_reg(CFG_IDX_W'(REG_GRADE0 + g), '0);
			end else begin
				write_reg(REG_SET_TEMP, ($urandom_range(0, 4) == 0) ?
					{$urandom, $urandom} : WORD_W'(int'($urandom_range(0, 6000)) - 3000));
				for (int g = 0; g < MAX_GRADE_REGS; g++) begin
					cyc = $urandom_range(0, 9);
					rn = ($urandom_range(0, 3) == 0) ? cyc : $urandom_range(0, 9);
					w = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} :
						pack_grade(int'($urandom_range(0, 5000)) - 2500, cyc, rn,
							MASK_W'($urandom));
					write_reg(CFG_IDX_W'(REG_GRADE0 + g), w);
				end
			end
			cfg_wr_en <= 1'b0;
			idle_on = (ph % 4 != 3) && (ph != RAND_PHASES - 1);
			repeat (TICKS_PER_PHASE) drive_tick(random_tick(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (fan_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Drove %0d ticks with %0d register writes; checked %0d result beats, %0d mismatches.",
			ticks_sent, cfg_writes, results_seen, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/vdc_pkg.sv
rtl/vdc_grade_pick.sv
rtl/vdc_duty_fsm.sv
rtl/ventilation_duty_cycle_controller_core.sv
tb/sv/tb.sv
